@@ rtl/core/set_associative_key_value_table_unit_assert.svh @@
// Assertion macros for the set-associative key/value table.
// Each macro expands to one labeled concurrent assertion, reset-gated.
`ifndef SET_ASSOCIATIVE_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define SET_ASSOCIATIVE_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SAKV_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sakv assertion failed");

// Next-cycle implication.
`define SAKV_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sakv assertion failed");

`endif

@@ rtl/core/sakv_pkg.sv @@
// Package for the set-associative key/value table.
// Holds field widths, command and status codes, sequencer states and shared types.
`default_nettype none

package sakv_pkg;

  localparam int NUM_SETS_DEF = 32;
  localparam int WAYS_DEF     = 8;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 31;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic ent_we;
    logic vld_we;
  } store_ctl_t;

  function automatic int idx_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/set_associative_key_value_table_unit.sv @@
// Top level of the set-associative key/value table.
// Instantiates sakv_ctrl and sakv_store; depends on sakv_pkg.
//
// Usage:
// Requests arrive on the s_ stream (add, delete or get with a key and a value),
// and each one yields exactly one item on the m_ stream (status and read value).
// The set is the key modulo NUM_SETS; its WAYS ways are compared one per cycle
// by a single key comparator reading the entry memory, then a write-back
// step updates the entry and valid-row memories.
// Requests do not overlap: the next one is accepted only after write-back of the last.
// When NUM_SETS is not a power of two, a reciprocal multiplication at accept
// and a subtract step find the set first. Early key matches end the scan
// sooner. The result is registered and appears in the cycle after write-back.
// s_tready is high only while the sequencer is idle.
// Reset: after rst falls, a clearing pass of NUM_SETS cycles zeroes the valid
// rows, one set per cycle, with s_tready low.
// Stall: a result waits in the output register while m_tready is low; the
// next request may be accepted and processed, and its write-back waits until
// the output register is free.
`default_nettype none

module set_associative_key_value_table_unit
  import sakv_pkg::*;
#(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int WAYS     = WAYS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // command[1:0], key[32:2], value[64:33], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata    // status[1:0], read_value[33:2], zero pad
);

  localparam int SET_W  = idx_w(NUM_SETS);
  localparam int ADDR_W = idx_w(NUM_SETS * WAYS);

  store_ctl_t          ctl;
  logic [ADDR_W-1:0]   ent_addr;
  logic [KEY_W-1:0]    ent_wkey;
  logic [VALUE_W-1:0]  ent_wval;
  logic [KEY_W-1:0]    ent_rkey;
  logic [VALUE_W-1:0]  ent_rval;
  logic [SET_W-1:0]    vld_addr;
  logic [WAYS-1:0]     vld_wdata;
  logic [WAYS-1:0]     vld_rdata;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  read_value;

  assign m_tdata = {6'b0, read_value, status};

  sakv_ctrl #(
    .NUM_SETS (NUM_SETS),
    .WAYS     (WAYS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .command    (s_tdata[1:0]),
    .key        (s_tdata[32:2]),
    .value      (s_tdata[64:33]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .status     (status),
    .read_value (read_value),
    .ctl        (ctl),
    .ent_addr   (ent_addr),
    .ent_wkey   (ent_wkey),
    .ent_wval   (ent_wval),
    .ent_rkey   (ent_rkey),
    .ent_rval   (ent_rval),
    .vld_addr   (vld_addr),
    .vld_wdata  (vld_wdata),
    .vld_rdata  (vld_rdata)
  );

  sakv_store #(
    .NUM_SETS (NUM_SETS),
    .WAYS     (WAYS)
  ) u_store (
    .clk       (clk),
    .ctl       (ctl),
    .ent_addr  (ent_addr),
    .ent_wkey  (ent_wkey),
    .ent_wval  (ent_wval),
    .ent_rkey  (ent_rkey),
    .ent_rval  (ent_rval),
    .vld_addr  (vld_addr),
    .vld_wdata (vld_wdata),
    .vld_rdata (vld_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/core/sakv_store.sv @@
// Storage of the key/value table: one entry memory and one valid-row memory.
// Both have registered read data; depends on sakv_pkg.
`default_nettype none

module sakv_store
  import sakv_pkg::*;
#(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int WAYS     = WAYS_DEF
) (
  input  wire logic                                   clk,
  input  wire store_ctl_t                             ctl,
  input  wire logic [idx_w(NUM_SETS*WAYS)-1:0]        ent_addr,
  input  wire logic [KEY_W-1:0]                       ent_wkey,
  input  wire logic [VALUE_W-1:0]                     ent_wval,
  output logic      [KEY_W-1:0]                       ent_rkey,
  output logic      [VALUE_W-1:0]                     ent_rval,
  input  wire logic [idx_w(NUM_SETS)-1:0]             vld_addr,
  input  wire logic [WAYS-1:0]                        vld_wdata,
  output logic      [WAYS-1:0]                        vld_rdata
);

  localparam int TABLE_SIZE = NUM_SETS * WAYS;

  logic [KEY_W+VALUE_W-1:0] ent_mem [TABLE_SIZE];
  logic [WAYS-1:0]          vld_mem [NUM_SETS];

  always_ff @(posedge clk) begin
    if (ctl.ent_we) begin
      ent_mem[ent_addr] <= {ent_wkey, ent_wval};
    end
    {ent_rkey, ent_rval} <= ent_mem[ent_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.vld_we) begin
      vld_mem[vld_addr] <= vld_wdata;
    end
    vld_rdata <= vld_mem[vld_addr];
  end

endmodule

`default_nettype wire

@@ rtl/core/sakv_ctrl.sv @@
// Sequencer of the key/value table: reset clearing, set reduction, way-by-way scan, write-back.
// Drives the storage in sakv_store and holds the output register; depends on sakv_pkg.
`default_nettype none

module sakv_ctrl
  import sakv_pkg::*;
#(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int WAYS     = WAYS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [CMD_W-1:0]                       command,
  input  wire logic [KEY_W-1:0]                       key,
  input  wire logic [VALUE_W-1:0]                     value,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic      [STATUS_W-1:0]                    status,
  output logic      [VALUE_W-1:0]                     read_value,
  output store_ctl_t                                  ctl,
  output logic      [idx_w(NUM_SETS*WAYS)-1:0]        ent_addr,
  output logic      [KEY_W-1:0]                       ent_wkey,
  output logic      [VALUE_W-1:0]                     ent_wval,
  input  wire logic [KEY_W-1:0]                       ent_rkey,
  input  wire logic [VALUE_W-1:0]                     ent_rval,
  output logic      [idx_w(NUM_SETS)-1:0]             vld_addr,
  output logic      [WAYS-1:0]                        vld_wdata,
  input  wire logic [WAYS-1:0]                        vld_rdata
);

  localparam int SET_W     = idx_w(NUM_SETS);
  localparam int ADDR_W    = idx_w(NUM_SETS * WAYS);
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam bit IS_POW2   = (NUM_SETS & (NUM_SETS - 1)) == 0;
  localparam int MOD_SHIFT = KEY_W + $clog2(NUM_SETS);
  localparam logic [VALUE_W-1:0] RECIP =
    VALUE_W'(((64'd1 << MOD_SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));

  state_t state, state_next;

  logic [CMD_W-1:0]   cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic [SET_W-1:0]   set_r;
  logic [KEY_W-1:0]   quot;
  logic [SET_W-1:0]   clr_cnt;
  logic [WAY_W-1:0]   issue_way;
  logic               pend;
  logic [WAY_W-1:0]   pend_way;
  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic [VALUE_W-1:0] hit_val;
  logic               free_found;
  logic [WAY_W-1:0]   free_way;

  logic [KEY_W+VALUE_W-1:0] recip_prod;
  logic [SET_W-1:0]   set_mod;
  logic               slot_free;
  logic               way_valid;
  logic               cmp_match;
  logic               scan_last;
  logic [ADDR_W-1:0]  base;
  logic [SET_W-1:0]   key_masked;

  assign slot_free  = !out_valid || out_ready;
  assign recip_prod = (KEY_W+VALUE_W)'(key) * (KEY_W+VALUE_W)'(RECIP);
  assign set_mod    = SET_W'(key_r - quot * KEY_W'(NUM_SETS));
  assign way_valid  = vld_rdata[pend_way];
  assign cmp_match  = pend && way_valid && (ent_rkey == key_r);
  assign scan_last  = pend && (cmp_match || pend_way == WAY_W'(WAYS - 1));
  assign base       = ADDR_W'(set_r) * ADDR_W'(WAYS);
  assign key_masked = key[SET_W-1:0] & SET_W'(NUM_SETS - 1);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == SET_W'(NUM_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = IS_POW2 ? ST_SCAN : ST_MOD;
        end
      end
      ST_MOD: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ctl        = '0;
    ent_addr   = base + ADDR_W'(issue_way);
    ent_wkey   = key_r;
    ent_wval   = value_r;
    vld_addr   = set_r;
    vld_wdata  = vld_rdata;
    case (state)
      ST_CLEAR: begin
        vld_addr   = clr_cnt;
        vld_wdata  = '0;
        ctl.vld_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_FINISH: begin
        ent_addr = base + ADDR_W'(hit ? hit_way : free_way);
        if (slot_free) begin
          if (cmd_r == CMD_ADD && (hit || free_found)) begin
            ctl.ent_we = 1'b1;
          end
          if (cmd_r == CMD_ADD && !hit && free_found) begin
            ctl.vld_we = 1'b1;
            vld_wdata  = vld_rdata | (WAYS'(1) << free_way);
          end
          if (cmd_r == CMD_DELETE && hit) begin
            ctl.vld_we = 1'b1;
            vld_wdata  = vld_rdata & ~(WAYS'(1) << hit_way);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
      if (state == ST_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_SCAN) begin
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cmd_r      <= command;
      key_r      <= key;
      value_r    <= value;
      set_r      <= key_masked;
      quot       <= KEY_W'(recip_prod >> MOD_SHIFT);
      issue_way  <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end
    if (state == ST_MOD) begin
      set_r <= set_mod;
    end
    if (state == ST_SCAN) begin
      pend_way <= issue_way;
      if (issue_way != WAY_W'(WAYS - 1)) begin
        issue_way <= issue_way + WAY_W'(1);
      end
      if (cmp_match) begin
        hit     <= 1'b1;
        hit_way <= pend_way;
        hit_val <= ent_rval;
      end
      if (pend && !way_valid && !free_found) begin
        free_found <= 1'b1;
        free_way   <= pend_way;
      end
    end
    if (state == ST_FINISH && slot_free) begin
      status     <= STATUS_DONE;
      read_value <= '0;
      case (cmd_r)
        CMD_ADD: begin
          if (!hit && !free_found) begin
            status <= STATUS_FULL;
          end
        end
        CMD_DELETE: begin
          if (!hit) begin
            status <= STATUS_NOT_FOUND;
          end
        end
        CMD_GET: begin
          if (hit) begin
            read_value <= hit_val;
          end else begin
            status <= STATUS_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sakv_checker.sv @@
// Port-level assertions for the set-associative key/value table.
// Uses the macros of set_associative_key_value_table_unit_assert.svh; bound to the top level.
`default_nettype none

`include "set_associative_key_value_table_unit_assert.svh"

module sakv_checker
  import sakv_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  logic [STATUS_W-1:0] m_status;
  logic [VALUE_W-1:0]  m_read_value;
  logic                status_known;

  assign m_status     = m_tdata[1:0];
  assign m_read_value = m_tdata[33:2];
  assign status_known = (m_status == STATUS_DONE) || (m_status == STATUS_NOT_FOUND) ||
                        (m_status == STATUS_FULL);

  `SAKV_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SAKV_ASSERT_IMPL(a_status_code, clk, rst, m_tvalid, status_known)
  `SAKV_ASSERT_IMPL(a_miss_zero, clk, rst, m_tvalid && m_status != STATUS_DONE, m_read_value == '0)
  `SAKV_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind set_associative_key_value_table_unit sakv_checker u_sakv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/set_associative_key_value_table_unit_test.sv @@
// Self-checking testbench for the set-associative key/value table.
// A scoreboard class predicts each status and read value from its own copy of the table.
// Depends on sakv_pkg and the set_associative_key_value_table_unit top level.

import sakv_pkg::*;

typedef struct packed {
  logic [CMD_W-1:0]          cmd;
  logic [KEY_W-1:0]          key;
  logic signed [VALUE_W-1:0] value;
} kv_request_t;

typedef struct packed {
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] read_value;
} kv_response_t;

class kv_table_tracker;
  localparam int unsigned SETS = NUM_SETS_DEF;
  localparam int unsigned NWAYS = WAYS_DEF;

  bit                        way_valid[SETS*NWAYS];
  logic [KEY_W-1:0]          way_key[SETS*NWAYS];
  logic signed [VALUE_W-1:0] way_value[SETS*NWAYS];
  kv_response_t              expected_responses[$];
  int                        failures;
  int                        requests;
  int                        status_seen[4];

  function new();
    failures = 0;
    requests = 0;
    foreach (way_valid[i]) way_valid[i] = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function int pending();
    return expected_responses.size();
  endfunction

  function void flag(string msg);
    failures++;
    if (failures <= 10) $display("ERROR: %s", msg);
  endfunction

  function void note_request(kv_request_t req);
    int unsigned  base;
    int           hit_way;
    int           free_way;
    kv_response_t rsp;
    base = (req.key % SETS) * NWAYS;
    hit_way = -1;
    free_way = -1;
    for (int w = 0; w < NWAYS; w++) begin
      if (way_valid[base+w] && way_key[base+w] == req.key && hit_way < 0) hit_way = w;
      if (!way_valid[base+w] && free_way < 0) free_way = w;
    end
    rsp.status = STATUS_DONE;
    rsp.read_value = '0;
    case (req.cmd)
      CMD_ADD: begin
        if (hit_way >= 0) begin
          way_value[base+hit_way] = req.value;
        end else if (free_way >= 0) begin
          way_key[base+free_way] = req.key;
          way_value[base+free_way] = req.value;
          way_valid[base+free_way] = 1'b1;
        end else begin
          rsp.status = STATUS_FULL;
        end
      end
      CMD_DELETE: begin
        if (hit_way >= 0) way_valid[base+hit_way] = 1'b0;
        else rsp.status = STATUS_NOT_FOUND;
      end
      CMD_GET: begin
        if (hit_way >= 0) rsp.read_value = way_value[base+hit_way];
        else rsp.status = STATUS_NOT_FOUND;
      end
      default: ;
    endcase
    requests++;
    status_seen[rsp.status]++;
    expected_responses.push_back(rsp);
  endfunction

  function void check_response(logic [STATUS_W-1:0] status, logic signed [VALUE_W-1:0] rd);
    kv_response_t exp_rsp;
    if (expected_responses.size() == 0) begin
      flag($sformatf("result with nothing expected: status %0d value %0h", status, rd));
      return;
    end
    exp_rsp = expected_responses.pop_front();
    if (status !== exp_rsp.status)
      flag($sformatf("status expected %0d actual %0d", exp_rsp.status, status));
    if (rd !== exp_rsp.read_value)
      flag($sformatf("read_value expected %0h actual %0h", exp_rsp.read_value, rd));
  endfunction
endclass

module set_associative_key_value_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SETS = NUM_SETS_DEF;
  localparam int WAYS = WAYS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // command[1:0], key[32:2], value[64:33], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // status[1:0], read_value[33:2], zero pad

  kv_table_tracker tracker = new();

  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;

  set_associative_key_value_table_unit #(
    .NUM_SETS(NUM_SETS),
    .WAYS    (WAYS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [KEY_W-1:0] key_in_set(int unsigned tag, int unsigned set_idx);
    return KEY_W'(tag * NUM_SETS + set_idx);
  endfunction

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                              logic signed [VALUE_W-1:0] value);
    kv_request_t req;
    req.cmd = cmd;
    req.key = key;
    req.value = value;
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, value, key, cmd};
    do @(negedge clk); while (!s_tready);
    tracker.note_request(req);
    @(posedge clk);
  endtask

  task automatic idle(int unsigned cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case (cycle_count[10:9])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: begin
        if (hold_left == 0) begin
          m_tready <= !m_tready;
          hold_left <= m_tready ? $urandom_range(1, 12) : $urandom_range(1, 4);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
      default: m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_response(m_tdata[1:0], m_tdata[33:2]);
  end

  initial begin
    #1ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned               sent;
    int unsigned               burst;
    int unsigned               roll;
    int unsigned               set_idx;
    int unsigned               tag;
    int unsigned               max_tag;
    bit                        drained_mid;
    bit                        fill_phase;
    logic [CMD_W-1:0]          cmd;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
    int unsigned               focus_sets[4];

    focus_sets = '{0, 1, NUM_SETS - 1, NUM_SETS / 2};
    max_tag = 32'h7FFF_FFFF / NUM_SETS;
    sent = 0;
    drained_mid = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(CMD_GET, '0, 32'sd0);
    send_request(CMD_DELETE, '0, -32'sd1);
    for (int t = 0; t < WAYS; t++) begin
      case (t % 4)
        0: value = 32'sh8000_0000;
        1: value = 32'sh7FFF_FFFF;
        2: value = 32'sd0;
        default: value = -32'sd1;
      endcase
      send_request(CMD_ADD, key_in_set(t, 3 % NUM_SETS), value);
    end
    send_request(CMD_ADD, key_in_set(WAYS, 3 % NUM_SETS), 32'sh1234_5678);
    send_request(CMD_ADD, key_in_set(WAYS / 2, 3 % NUM_SETS), 32'sh5A5A_A5A5);
    send_request(CMD_GET, key_in_set(WAYS / 2, 3 % NUM_SETS), 32'sd0);
    send_request(CMD_DELETE, key_in_set(WAYS - 1, 3 % NUM_SETS), 32'sd0);
    send_request(CMD_GET, key_in_set(WAYS - 1, 3 % NUM_SETS), 32'sd0);
    send_request(CMD_ADD, key_in_set(WAYS + 1, 3 % NUM_SETS), 32'sh0F0F_F0F0);
    send_request(CMD_GET, key_in_set(WAYS + 1, 3 % NUM_SETS), 32'sd0);
    send_request(CMD_GET, key_in_set(WAYS, 3 % NUM_SETS), 32'sd0);
    send_request(CMD_UNUSED, 31'h7FFF_FFFF, -32'sd1);
    send_request(CMD_ADD, 31'h7FFF_FFFF, 32'sh8000_0000);
    send_request(CMD_GET, 31'h7FFF_FFFF, 32'sh7FFF_FFFF);
    send_request(CMD_DELETE, 31'h7FFF_FFFF, 32'sd0);
    send_request(CMD_GET, 31'h7FFF_FFFF, 32'sd0);

    idle(1);
    wait_drained();

    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst; b++) begin
        fill_phase = ((sent / 200) % 2) == 0;
        roll = $urandom_range(0, 99);
        if (fill_phase)
          cmd = (roll < 55) ? CMD_ADD : (roll < 70) ? CMD_DELETE :
                (roll < 96) ? CMD_GET : CMD_UNUSED;
        else
          cmd = (roll < 25) ? CMD_ADD : (roll < 60) ? CMD_DELETE :
                (roll < 95) ? CMD_GET : CMD_UNUSED;
        if ($urandom_range(0, 99) < 8) begin
          key = KEY_W'($urandom());
        end else begin
          set_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_SETS - 1)
                                                : focus_sets[$urandom_range(0, 3)];
          tag = $urandom_range(0, WAYS + 3);
          if ($urandom_range(0, 3) == 0) tag = max_tag - 1 - tag;
          key = key_in_set(tag, set_idx);
        end
        roll = $urandom_range(0, 15);
        value = (roll == 0) ? 32'sh8000_0000 : (roll == 1) ? 32'sh7FFF_FFFF :
                VALUE_W'($urandom());
        send_request(cmd, key, value);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
      if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
        idle(1);
        wait_drained();
        drained_mid = 1'b1;
      end
    end

    idle(1);
    wait_drained();
    repeat (4 * WAYS + 40) @(posedge clk);
    if (tracker.pending() != 0) tracker.flag("results still outstanding at the end");

    $display("Ran %0d requests: %0d done or hit, %0d not found, %0d dropped on a full set.",
             tracker.requests, tracker.status_seen[STATUS_DONE],
             tracker.status_seen[STATUS_NOT_FOUND], tracker.status_seen[STATUS_FULL]);
    $display("Mismatches and stray results: %0d.", tracker.failures);
    if (tracker.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
